>>> hdl/hve_pkg.sv
// Package for the header value extractor: item types, result kinds, scan
// phase and line-end codes, register indexes and name helpers.
// No dependencies.
package hve_pkg;

    // Longest header name that can match
    localparam int MAX_NAME_LEN = 16;
    localparam int NAME_LEN_W   = 5;
    localparam int NAME_BITS    = 8 * MAX_NAME_LEN;
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_IDX_W    = 3;
    // Most results one input item can cause
    localparam int MAX_RESULTS  = 5;
    localparam int RES_IDX_W    = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_LOW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_HIGH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_LEN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_HIGH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_LEN  = 3'd5;

    // Result kinds
    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    // Scan phases
    localparam logic [2:0] PH_SKIP       = 3'd0;
    localparam logic [2:0] PH_AFTER_CR   = 3'd1;
    localparam logic [2:0] PH_LINE_START = 3'd2;
    localparam logic [2:0] PH_NAME       = 3'd3;
    localparam logic [2:0] PH_POST_NAME  = 3'd4;
    localparam logic [2:0] PH_LEAD       = 3'd5;
    localparam logic [2:0] PH_VALUE      = 3'd6;

    // Line end held back inside a value
    localparam logic [1:0] PEND_NONE = 2'd0;
    localparam logic [1:0] PEND_CR   = 2'd1;
    localparam logic [1:0] PEND_CRLF = 2'd2;
    localparam logic [1:0] PEND_LF   = 2'd3;

    // Characters
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value_byte;
        logic [7:0] match_count;
    } out_item_t;

    // ASCII lower-case fold
    function automatic logic [7:0] fold(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    // Character at position pos of a packed name
    function automatic logic [7:0] name_char(input logic [NAME_BITS-1:0] name,
                                             input logic [3:0] pos);
        return name[8*pos +: 8];
    endfunction

endpackage

>>> hdl/header_value_extract.sv
// Header value extractor top level: input register, per-byte scan logic
// and a result group register, drained one item per cycle while m_ready
// is high. Depends on hve_pkg.
//
// Usage:
//   s_ channel: one message byte per item (data_byte, last_byte marks the
//   final byte of the message). m_ channel: result items (value byte,
//   value end, search finished) with the running match count.
//   cfg_we/cfg_index/cfg_wdata write the two header names and lengths;
//   write only while the block is idle.
// Path: an accepted item is held in the input register; its results are
//   computed from it and loaded into the result group register once that
//   register is free, and are then offered on m_data in order.
// Throughput: one byte per cycle while each byte causes at most one
//   result and m_ready stays high. A byte with more results (up to five,
//   e.g. folded line end, value end, finish) holds the group till drained.
// Reset: aresetn low clears the scan state and both names (names disabled),
//   the first line is skipped again, no item is pending.
// Stall: with m_ready low the group register holds its results, the input
//   register still takes one more byte, then s_ready drops.
module header_value_extract
    import hve_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    // Configuration registers
    logic [NAME_BITS-1:0]  name_a_reg;
    logic [NAME_BITS-1:0]  name_b_reg;
    logic [NAME_LEN_W-1:0] len_a_reg;
    logic [NAME_LEN_W-1:0] len_b_reg;

    // Scan state
    logic [2:0]            phase_reg, phase_next;
    logic [NAME_LEN_W-1:0] pos_reg, pos_next;
    logic [1:0]            match_reg, match_next;
    logic [1:0]            pend_reg, pend_next;
    logic [7:0]            found_reg, found_next;
    logic                  done_reg, done_next;

    // Input register
    logic     in_valid_reg;
    in_item_t in_reg;

    // Result group register
    logic [1:0]           grp_kind_reg [MAX_RESULTS];
    logic [7:0]           grp_byte_reg [MAX_RESULTS];
    logic [RES_IDX_W-1:0] grp_cnt_reg;
    logic [RES_IDX_W-1:0] grp_idx_reg;
    logic [7:0]           grp_match_reg;

    // Results of the byte in the input register
    logic [1:0]           res_kind [MAX_RESULTS];
    logic [7:0]           res_byte [MAX_RESULTS];
    logic [RES_IDX_W-1:0] res_cnt;

    logic grp_last_taken;
    logic grp_free;
    logic proc_fire;

    // Handshake
    assign m_valid        = (grp_idx_reg != grp_cnt_reg);
    assign grp_last_taken = m_valid && m_ready && (grp_idx_reg == grp_cnt_reg - 3'd1);
    assign grp_free       = !m_valid || grp_last_taken;
    assign proc_fire      = in_valid_reg && grp_free;
    assign s_ready        = !in_valid_reg || proc_fire;

    assign m_data.kind        = grp_kind_reg[grp_idx_reg];
    assign m_data.value_byte  = grp_byte_reg[grp_idx_reg];
    assign m_data.match_count = grp_match_reg;

    // Name compare for one character
    function automatic logic [1:0] cmp_char(input logic [1:0] mt,
                                            input logic [NAME_LEN_W-1:0] pos,
                                            input logic [7:0] b,
                                            input logic [NAME_BITS-1:0] na,
                                            input logic [NAME_LEN_W-1:0] la,
                                            input logic [NAME_BITS-1:0] nb,
                                            input logic [NAME_LEN_W-1:0] lb);
        logic [1:0] r;
        logic       in_range;
        r = mt;
        in_range = (pos < NAME_LEN_W'(MAX_NAME_LEN));
        if (!(in_range && pos < la && fold(b) == fold(name_char(na, pos[3:0])))) begin
            r[0] = 1'b0;
        end
        if (!(in_range && pos < lb && fold(b) == fold(name_char(nb, pos[3:0])))) begin
            r[1] = 1'b0;
        end
        return r;
    endfunction

    // Per-byte scan step
    always_comb begin
        logic [7:0] b;
        logic       last;
        logic       blank;
        logic       do_value;
        logic       do_ls;
        logic       do_skip;
        logic       do_decide;
        logic       hit_a;
        logic       hit_b;
        logic       in_value;
        b          = in_reg.data_byte;
        last       = in_reg.last_byte;
        blank      = (b == CH_SPACE) || (b == CH_TAB);
        do_value   = 1'b0;
        do_ls      = 1'b0;
        do_skip    = 1'b0;
        do_decide  = 1'b0;
        phase_next = phase_reg;
        pos_next   = pos_reg;
        match_next = match_reg;
        pend_next  = pend_reg;
        found_next = found_reg;
        done_next  = done_reg;
        res_cnt    = '0;
        for (int i = 0; i < MAX_RESULTS; i++) begin
            res_kind[i] = KIND_BYTE;
            res_byte[i] = '0;
        end

        if (!done_reg) begin
            // Phase dispatch
            case (phase_reg)
                PH_SKIP: begin
                    do_skip = 1'b1;
                end
                PH_AFTER_CR: begin
                    if (b == CH_LF) begin
                        phase_next = PH_LINE_START;
                    end else begin
                        do_ls = 1'b1;
                    end
                end
                PH_LINE_START: begin
                    do_ls = 1'b1;
                end
                PH_NAME: begin
                    if (b > CH_SPACE && b != CH_COLON) begin
                        match_next = cmp_char(match_reg, pos_reg, b, name_a_reg,
                                              len_a_reg, name_b_reg, len_b_reg);
                        if (pos_reg <= NAME_LEN_W'(MAX_NAME_LEN)) begin
                            pos_next = pos_reg + 5'd1;
                        end
                    end else if (blank) begin
                        phase_next = PH_POST_NAME;
                    end else if (b == CH_COLON) begin
                        do_decide = 1'b1;
                    end else begin
                        do_skip = 1'b1;
                    end
                end
                PH_POST_NAME: begin
                    if (b == CH_COLON) begin
                        do_decide = 1'b1;
                    end else if (!blank) begin
                        do_skip = 1'b1;
                    end
                end
                PH_LEAD: begin
                    if (!blank) begin
                        phase_next = PH_VALUE;
                        pend_next  = PEND_NONE;
                        do_value   = 1'b1;
                    end
                end
                PH_VALUE: begin
                    do_value = 1'b1;
                end
                default: begin
                    phase_next = PH_SKIP;
                end
            endcase

            // Value bytes, with line ends held until folding is known
            if (do_value) begin
                case (pend_next)
                    PEND_NONE: begin
                        if (b == CH_TAB || b >= CH_SPACE) begin
                            res_kind[res_cnt] = KIND_BYTE;
                            res_byte[res_cnt] = b;
                            res_cnt = res_cnt + 3'd1;
                        end else if (b == CH_CR) begin
                            pend_next = PEND_CR;
                        end else if (b == CH_LF) begin
                            pend_next = PEND_LF;
                        end else begin
                            res_kind[res_cnt] = KIND_END;
                            res_cnt = res_cnt + 3'd1;
                            res_kind[res_cnt] = KIND_DONE;
                            res_cnt = res_cnt + 3'd1;
                            pend_next = PEND_NONE;
                            done_next = 1'b1;
                        end
                    end
                    PEND_CR: begin
                        if (b == CH_LF) begin
                            pend_next = PEND_CRLF;
                        end else if (blank) begin
                            res_kind[res_cnt] = KIND_BYTE;
                            res_byte[res_cnt] = CH_CR;
                            res_cnt = res_cnt + 3'd1;
                            res_kind[res_cnt] = KIND_BYTE;
                            res_byte[res_cnt] = b;
                            res_cnt = res_cnt + 3'd1;
                            pend_next = PEND_NONE;
                        end else begin
                            res_kind[res_cnt] = KIND_END;
                            res_cnt = res_cnt + 3'd1;
                            pend_next = PEND_NONE;
                            do_ls = 1'b1;
                        end
                    end
                    default: begin
                        if (blank) begin
                            if (pend_next == PEND_CRLF) begin
                                res_kind[res_cnt] = KIND_BYTE;
                                res_byte[res_cnt] = CH_CR;
                                res_cnt = res_cnt + 3'd1;
                            end
                            res_kind[res_cnt] = KIND_BYTE;
                            res_byte[res_cnt] = CH_LF;
                            res_cnt = res_cnt + 3'd1;
                            res_kind[res_cnt] = KIND_BYTE;
                            res_byte[res_cnt] = b;
                            res_cnt = res_cnt + 3'd1;
                            pend_next = PEND_NONE;
                        end else begin
                            res_kind[res_cnt] = KIND_END;
                            res_cnt = res_cnt + 3'd1;
                            pend_next = PEND_NONE;
                            do_ls = 1'b1;
                        end
                    end
                endcase
            end

            // Start of a line: folded, empty, or a new name
            if (do_ls) begin
                if (blank) begin
                    phase_next = PH_SKIP;
                end else if (b > CH_SPACE && b != CH_COLON) begin
                    match_next = cmp_char(2'b11, '0, b, name_a_reg, len_a_reg,
                                          name_b_reg, len_b_reg);
                    pos_next   = 5'd1;
                    phase_next = PH_NAME;
                end else begin
                    res_kind[res_cnt] = KIND_DONE;
                    res_cnt = res_cnt + 3'd1;
                    done_next = 1'b1;
                end
            end

            // Rest of a line that is not scanned
            if (do_skip) begin
                if (b == CH_TAB || b >= CH_SPACE) begin
                    phase_next = PH_SKIP;
                end else if (b == CH_CR) begin
                    phase_next = PH_AFTER_CR;
                end else if (b == CH_LF) begin
                    phase_next = PH_LINE_START;
                end else begin
                    res_kind[res_cnt] = KIND_DONE;
                    res_cnt = res_cnt + 3'd1;
                    done_next = 1'b1;
                end
            end

            // Colon: did either name match in full
            if (do_decide) begin
                hit_a = match_reg[0] && len_a_reg != '0 &&
                        len_a_reg <= NAME_LEN_W'(MAX_NAME_LEN) && pos_reg == len_a_reg;
                hit_b = match_reg[1] && len_b_reg != '0 &&
                        len_b_reg <= NAME_LEN_W'(MAX_NAME_LEN) && pos_reg == len_b_reg;
                if (hit_a || hit_b) begin
                    if (found_reg != 8'hFF) begin
                        found_next = found_reg + 8'd1;
                    end
                    pend_next  = PEND_NONE;
                    phase_next = PH_LEAD;
                end else begin
                    phase_next = PH_SKIP;
                end
            end else begin
                hit_a = 1'b0;
                hit_b = 1'b0;
            end

            // Last byte closes an open value and the search
            if (last && !done_next) begin
                in_value = (phase_next == PH_LEAD) || (phase_next == PH_VALUE);
                if (in_value) begin
                    res_kind[res_cnt] = KIND_END;
                    res_cnt = res_cnt + 3'd1;
                end
                res_kind[res_cnt] = KIND_DONE;
                res_cnt = res_cnt + 3'd1;
            end else begin
                in_value = 1'b0;
            end
        end else begin
            hit_a    = 1'b0;
            hit_b    = 1'b0;
            in_value = 1'b0;
        end

        // Every last byte rearms the scan
        if (last) begin
            phase_next = PH_SKIP;
            pos_next   = '0;
            match_next = 2'b11;
            pend_next  = PEND_NONE;
            done_next  = 1'b0;
        end
    end

    // Count shown with this byte's results is the count before rearm
    logic [7:0] res_match;
    assign res_match = found_next;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            name_a_reg <= '0;
            name_b_reg <= '0;
            len_a_reg  <= '0;
            len_b_reg  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_FIRST_LOW:   name_a_reg[CFG_DATA_W-1:0]         <= cfg_wdata;
                REG_FIRST_HIGH:  name_a_reg[NAME_BITS-1:CFG_DATA_W] <= cfg_wdata;
                REG_FIRST_LEN:   len_a_reg  <= cfg_wdata[NAME_LEN_W-1:0];
                REG_SECOND_LOW:  name_b_reg[CFG_DATA_W-1:0]         <= cfg_wdata;
                REG_SECOND_HIGH: name_b_reg[NAME_BITS-1:CFG_DATA_W] <= cfg_wdata;
                REG_SECOND_LEN:  len_b_reg  <= cfg_wdata[NAME_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_reg <= s_data;
        end
    end

    // Scan state and result group
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_SKIP;
            pos_reg     <= '0;
            match_reg   <= 2'b11;
            pend_reg    <= PEND_NONE;
            found_reg   <= '0;
            done_reg    <= 1'b0;
            grp_cnt_reg <= '0;
            grp_idx_reg <= '0;
        end else if (proc_fire) begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            match_reg   <= match_next;
            pend_reg    <= pend_next;
            found_reg   <= in_reg.last_byte ? 8'd0 : found_next;
            done_reg    <= done_next;
            grp_cnt_reg <= res_cnt;
            grp_idx_reg <= '0;
        end else if (m_valid && m_ready) begin
            grp_idx_reg <= grp_idx_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_fire) begin
            grp_match_reg <= res_match;
            for (int i = 0; i < MAX_RESULTS; i++) begin
                grp_kind_reg[i] <= res_kind[i];
                grp_byte_reg[i] <= res_byte[i];
            end
        end
    end

endmodule
